// ===== rtl/voice_allocator_oldest_steal_defines.svh =====
// Assertion macros used by the voice allocator checker.
`ifndef VOICE_ALLOCATOR_OLDEST_STEAL_DEFINES_SVH
`define VOICE_ALLOCATOR_OLDEST_STEAL_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define VAOS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// Next-cycle implication, masked while reset is asserted.
`define VAOS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

// ===== rtl/vaos_pkg.sv =====
// Package for the voice allocator: sizes, opcodes, state type and voice entry.
package vaos_pkg;

    // Number of voices and the index width that follows from it
    localparam int VOICES  = 8;
    localparam int VW      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int STAMP_W = 32;

    // Event opcodes
    localparam logic [1:0] OP_NOTE_ON   = 2'd0;
    localparam logic [1:0] OP_NOTE_OFF  = 2'd1;
    localparam logic [1:0] OP_VOICE_END = 2'd2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // One voice as held in the voice memory
    typedef struct packed {
        logic [6:0]         note;
        logic [7:0]         velocity;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

endpackage

// ===== rtl/voice_allocator_oldest_steal.sv =====
// Voice allocator with oldest-voice stealing, voice data held in one memory.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------------------------
//  in       | i_in_valid   | o_in_stall   | i_opcode i_note i_velocity i_voice_index
//  out      | o_out_valid  | i_out_stall  | o_assigned_voice o_stolen o_released_mask
//           |              |              | o_active_mask
//
// Note on with an idle voice, voice finished and unused opcodes go from idle to done;
// note off and note on with every voice busy go through scan and drain before done;
// the voice memory is read one entry a cycle through its single read port.
// One word is worked on at a time; the next is taken once the result is in the
// output register, even while that register is still stalled.
// Synchronous reset clears all voice activity and the stamp counter; no memory sweep.
module voice_allocator_oldest_steal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [6:0] i_note,
    input  logic [7:0] i_velocity,
    input  logic [2:0] i_voice_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_assigned_voice,
    output logic       o_stolen,
    output logic [7:0] o_released_mask,
    output logic [7:0] o_active_mask
);
    import vaos_pkg::*;

    // Voice memory: note, velocity and stamp per voice
    t_entry mem [VOICES];

    t_state              r_state, n_state;
    logic [VOICES-1:0]   r_on;
    logic [STAMP_W-1:0]  r_stamp;

    // Latched input word
    logic [1:0]          r_op;
    logic [6:0]          r_note;
    logic [7:0]          r_vel;
    logic [2:0]          r_vidx;

    // Scan pipeline
    logic [VW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [VW-1:0]       r_rd_idx;
    t_entry              r_rd_data;
    logic [VW-1:0]       r_best_idx;
    logic [STAMP_W-1:0]  r_best_stamp;
    logic [VOICES-1:0]   r_rel;

    // Output register
    logic                r_out_valid;
    logic [2:0]          r_out_voice;
    logic                r_out_stolen;
    logic [7:0]          r_out_rel;
    logic [7:0]          r_out_act;

    logic                in_acc;
    logic                out_free;
    logic                rd_en;
    logic                done_fire;
    logic                scan_last;
    logic                all_busy;
    logic [VW-1:0]       free_idx;
    logic [VW-1:0]       target;
    logic                vidx_ok;
    logic [VW-1:0]       vidx_w;
    logic                wr_en;
    logic [VOICES-1:0]   rel;
    logic [VOICES-1:0]   set;
    logic [VOICES-1:0]   n_on;
    logic [STAMP_W-1:0]  n_stamp;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign scan_last = (r_addr == VW'(VOICES - 1));
    assign all_busy  = &r_on;

    // Lowest idle voice
    always_comb begin
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_on[i]) begin
                free_idx = VW'(i);
            end
        end
    end

    assign target  = all_busy ? r_best_idx : free_idx;
    assign vidx_ok = (32'(r_vidx) < VOICES);
    assign vidx_w  = VW'(r_vidx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_NOTE_OFF || (i_opcode == OP_NOTE_ON && &r_on)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        done_fire  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  rd_en      = 1'b1;
            S_DRAIN: ;
            S_DONE:  done_fire  = out_free;
            default: ;
        endcase
    end

    // Effect of the word at completion
    always_comb begin
        rel   = '0;
        set   = '0;
        wr_en = 1'b0;
        case (r_op)
            OP_NOTE_ON: begin
                set[target] = 1'b1;
                wr_en       = done_fire;
            end
            OP_NOTE_OFF: rel = r_rel;
            OP_VOICE_END: begin
                if (vidx_ok) begin
                    rel[vidx_w] = r_on[vidx_w];
                end
            end
            default: ;
        endcase
        n_on    = (r_on & ~rel) | set;
        n_stamp = r_stamp;
        if (r_op == OP_NOTE_ON && r_stamp != STAMP_MAX) begin
            n_stamp = r_stamp + 1'b1;
        end
    end

    // Voice memory write; sequencer keeps reads and writes apart in time
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[target] <= '{note: r_note, velocity: r_vel, stamp: r_stamp};
        end
    end

    // Voice memory read, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_on        <= '0;
            r_stamp     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (done_fire) begin
                r_on        <= n_on;
                r_stamp     <= n_stamp;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input word latch and scan address
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_opcode;
            r_note <= i_note;
            r_vel  <= i_velocity;
            r_vidx <= i_voice_index;
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + 1'b1;
        end
        r_rd_idx <= r_addr;
    end

    // Scan evaluation: oldest stamp and matching notes
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rel <= '0;
        end else if (r_rd_vld) begin
            if (r_rd_idx == '0 || r_rd_data.stamp < r_best_stamp) begin
                r_best_idx   <= r_rd_idx;
                r_best_stamp <= r_rd_data.stamp;
            end
            if (r_op == OP_NOTE_OFF && r_on[r_rd_idx] && r_rd_data.note == r_note) begin
                r_rel[r_rd_idx] <= 1'b1;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (done_fire) begin
            r_out_voice  <= (r_op == OP_NOTE_ON) ? 3'(target) : 3'd0;
            r_out_stolen <= (r_op == OP_NOTE_ON) && all_busy;
            r_out_rel    <= 8'(rel);
            r_out_act    <= 8'(n_on);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_assigned_voice = r_out_voice;
    assign o_stolen         = r_out_stolen;
    assign o_released_mask  = r_out_rel;
    assign o_active_mask    = r_out_act;

endmodule

// ===== rtl/vaos_checker.sv =====
// Port-level checker for the voice allocator, with its bind.
`include "voice_allocator_oldest_steal_defines.svh"

module vaos_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_assigned_voice,
    input logic       o_stolen,
    input logic [7:0] o_released_mask,
    input logic [7:0] o_active_mask
);

    // A stalled result word holds
    `VAOS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_released_mask) && $stable(o_active_mask) && $stable(o_assigned_voice))

    // One word at a time: input stalls right after an accepted word
    `VAOS_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // A released voice is never reported active
    `VAOS_ASSERT_IMP(a_rel_not_act, i_clk, i_rst_n, o_out_valid, (o_released_mask & o_active_mask) == 8'd0)

    // A steal releases nothing and leaves the assigned voice active
    `VAOS_ASSERT_IMP(a_steal_keeps, i_clk, i_rst_n, o_out_valid && o_stolen, o_released_mask == 8'd0 && o_active_mask[o_assigned_voice])

endmodule

bind voice_allocator_oldest_steal vaos_checker u_vaos_checker (.*);
